// ===== hw/rtl/bts_pkg.sv =====
package bts_pkg;

    // sequencer phase
    typedef enum logic [1:0] {
        PH_LOAD  = 2'd0,
        PH_COUNT = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    // frequency choice held in a rom entry
    typedef enum logic [1:0] {
        SEL_END  = 2'd0,
        SEL_LOW  = 2'd1,
        SEL_MID  = 2'd2,
        SEL_HIGH = 2'd3
    } freq_sel_t;

    // tone selector codes on a start transfer
    typedef enum logic [1:0] {
        TONE_SINGLE    = 2'd0,
        TONE_POWER_ON  = 2'd1,
        TONE_POWER_OFF = 2'd2,
        TONE_SPARE     = 2'd3
    } tone_t;

    // configuration register indexes
    localparam logic [1:0] REG_FREQ_LOW  = 2'd0;
    localparam logic [1:0] REG_FREQ_MID  = 2'd1;
    localparam logic [1:0] REG_FREQ_HIGH = 2'd2;

    localparam int unsigned CODE_LOW_RESET  = 2300;
    localparam int unsigned CODE_MID_RESET  = 2600;
    localparam int unsigned CODE_HIGH_RESET = 2900;

    localparam int unsigned ROM_IDX_W  = 4;
    localparam int unsigned TICK_W     = 8;
    localparam int unsigned OUT_FREQ_W = 16;

    typedef logic [ROM_IDX_W-1:0] rom_idx_t;
    typedef logic [TICK_W-1:0]    tick_t;

    typedef struct packed {
        freq_sel_t sel;
        tick_t     pwr;
        tick_t     osc;
    } rom_entry_t;

    // status levels handed from the core to the output stage
    typedef struct packed {
        logic power_on;
        logic osc_on;
        logic busy;
    } status_t;

    function automatic rom_entry_t rom_read(input rom_idx_t idx);
        rom_entry_t e;
        case (idx)
            4'd1:    e = '{SEL_MID,  8'd100, 8'd40};
            4'd3:    e = '{SEL_LOW,  8'd20,  8'd30};
            4'd4:    e = '{SEL_MID,  8'd20,  8'd30};
            4'd5:    e = '{SEL_HIGH, 8'd220, 8'd40};
            4'd7:    e = '{SEL_HIGH, 8'd20,  8'd30};
            4'd8:    e = '{SEL_MID,  8'd20,  8'd30};
            4'd9:    e = '{SEL_LOW,  8'd220, 8'd40};
            default: e = '{SEL_END,  8'd0,   8'd0};
        endcase
        return e;
    endfunction

    function automatic rom_idx_t seq_start(input tone_t tone);
        rom_idx_t idx;
        case (tone)
            TONE_POWER_ON:  idx = 4'd3;
            TONE_POWER_OFF: idx = 4'd7;
            default:        idx = 4'd1;
        endcase
        return idx;
    endfunction

endpackage

// ===== hw/rtl/bts_cfg.sv =====
module bts_cfg
    import bts_pkg::*;
#(
    parameter int FREQ_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [1:0]            wr_index,
    input  logic [FREQ_WIDTH-1:0] wr_data,
    output logic [FREQ_WIDTH-1:0] code_low,
    output logic [FREQ_WIDTH-1:0] code_mid,
    output logic [FREQ_WIDTH-1:0] code_high
);

    logic [FREQ_WIDTH-1:0] code_low_reg;
    logic [FREQ_WIDTH-1:0] code_mid_reg;
    logic [FREQ_WIDTH-1:0] code_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_low_reg  <= FREQ_WIDTH'(CODE_LOW_RESET);
            code_mid_reg  <= FREQ_WIDTH'(CODE_MID_RESET);
            code_high_reg <= FREQ_WIDTH'(CODE_HIGH_RESET);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FREQ_LOW:  code_low_reg  <= wr_data;
                REG_FREQ_MID:  code_mid_reg  <= wr_data;
                REG_FREQ_HIGH: code_high_reg <= wr_data;
                default:       ;   // unmapped index ignored
            endcase
        end
    end

    assign code_low  = code_low_reg;
    assign code_mid  = code_mid_reg;
    assign code_high = code_high_reg;

endmodule

// ===== hw/rtl/bts_core.sv =====
module bts_core
    import bts_pkg::*;
#(
    parameter int FREQ_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic                  mode,
    input  tone_t                 tone_select,
    input  logic [FREQ_WIDTH-1:0] code_low,
    input  logic [FREQ_WIDTH-1:0] code_mid,
    input  logic [FREQ_WIDTH-1:0] code_high,
    output status_t               status_next,
    output logic [FREQ_WIDTH-1:0] freq_next
);

    phase_t                phase_reg,  phase_next;
    rom_idx_t              index_reg,  index_next;
    tick_t                 pwr_left_reg, pwr_left_next;
    tick_t                 osc_left_reg, osc_left_next;
    logic                  power_reg,  power_next;
    logic                  osc_reg,    osc_next;
    logic [FREQ_WIDTH-1:0] freq_reg;
    logic [FREQ_WIDTH-1:0] entry_code;
    rom_entry_t            entry;

    assign entry = rom_read(index_reg);

    always_comb
    begin
        case (entry.sel)
            SEL_LOW: entry_code = code_low;
            SEL_MID: entry_code = code_mid;
            default: entry_code = code_high;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        index_next    = index_reg;
        pwr_left_next = pwr_left_reg;
        osc_left_next = osc_left_reg;
        power_next    = power_reg;
        osc_next      = osc_reg;
        freq_next     = freq_reg;
        if (step_en)
        begin
            if (mode)
            begin
                // start: restart at chosen sequence, timers load on next tick
                index_next = seq_start(tone_select);
                phase_next = PH_LOAD;
            end
            else
            begin
                case (phase_reg)
                    PH_LOAD:
                    begin
                        pwr_left_next = entry.pwr;
                        osc_left_next = entry.osc;
                        if (entry.sel == SEL_END || entry.pwr == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            pwr_left_next = entry.pwr - 1'b1;
                            power_next    = 1'b1;
                            if (entry.osc == '0)
                            begin
                                power_next = 1'b0;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                osc_left_next = entry.osc - 1'b1;
                                freq_next     = entry_code;
                                osc_next      = 1'b1;
                                phase_next    = PH_COUNT;
                            end
                        end
                    end
                    PH_COUNT:
                    begin
                        if (pwr_left_reg != '0)
                            pwr_left_next = pwr_left_reg - 1'b1;
                        else
                            power_next = 1'b0;
                        if (osc_left_reg != '0)
                        begin
                            osc_left_next = osc_left_reg - 1'b1;
                        end
                        else
                        begin
                            osc_next   = 1'b0;
                            index_next = index_reg + 1'b1;
                            phase_next = PH_LOAD;
                        end
                    end
                    default: ;   // finished: ticks change nothing
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LOAD;
            index_reg    <= '0;
            pwr_left_reg <= '0;
            osc_left_reg <= '0;
            power_reg    <= 1'b0;
            osc_reg      <= 1'b0;
            freq_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            pwr_left_reg <= pwr_left_next;
            osc_left_reg <= osc_left_next;
            power_reg    <= power_next;
            osc_reg      <= osc_next;
            freq_reg     <= freq_next;
        end
    end

    assign status_next.power_on = power_next;
    assign status_next.osc_on   = osc_next;
    assign status_next.busy     = (phase_next == PH_LOAD) || (phase_next == PH_COUNT);

endmodule

// ===== hw/rtl/buzzer_tone_sequencer_top.sv =====
// channel   | dir | handshake                     | payload
// ----------+-----+-------------------------------+------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: mode, tdata: tone_select
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: power_on, osc_on, freq_code,
//           |     |                               |        busy_res
// cfg       | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// one result per input transfer, in the cycle after it is taken; one transfer per cycle
// sustained while results are drained, set by the single registered update of the sequencer state
// reset (rst_n, async) puts the sequencer in the load phase at the end marker, rom entry 0,
// and the codes at their defaults; no clearing pass
// a stalled result holds in the output register and blocks new input; cfg always ready
module buzzer_tone_sequencer_top
    import bts_pkg::*;
#(
    parameter int FREQ_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [1:0] tone_select, [7:2] zero
    input  logic [0:0]            s_axis_tuser,   // [0] mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [0] power_on, [1] osc_on,
                                                  // [17:2] freq_code, [18] busy_res,
                                                  // [23:19] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [FREQ_WIDTH-1:0] cfg_data
);

    logic                  in_xfer;
    logic [FREQ_WIDTH-1:0] code_low;
    logic [FREQ_WIDTH-1:0] code_mid;
    logic [FREQ_WIDTH-1:0] code_high;
    status_t               status_next;
    logic [FREQ_WIDTH-1:0] freq_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg;
    logic [OUT_FREQ_W-1:0] out_freq_reg;

    // accept new input whenever the result slot is empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    bts_cfg #(
        .FREQ_WIDTH (FREQ_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_valid && cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .code_low  (code_low),
        .code_mid  (code_mid),
        .code_high (code_high)
    );

    bts_core #(
        .FREQ_WIDTH (FREQ_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (in_xfer),
        .mode        (s_axis_tuser[0]),
        .tone_select (tone_t'(s_axis_tdata[1:0])),
        .code_low    (code_low),
        .code_mid    (code_mid),
        .code_high   (code_high),
        .status_next (status_next),
        .freq_next   (freq_next)
    );

    assign out_valid_next = in_xfer || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_status_reg <= status_next;
            out_freq_reg   <= OUT_FREQ_W'(freq_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_status_reg.busy, out_freq_reg,
                            out_status_reg.osc_on, out_status_reg.power_on};

    // every input transfer yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("no result after input transfer");

    // oscillator only runs while a sequence is active
    a_osc_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[18])
        else $error("oscillator on while sequencer finished");

    // a stalled result blocks new input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

endmodule

// ===== tb/sv/tone_level_checker.sv =====
module tone_level_checker
    import bts_pkg::*;
#(
    parameter int FREQ_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_data,
    input  logic [0:0]        s_user,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [23:0]       m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [FREQ_W-1:0] cfg_data,
    output int                levels_pending,
    output int                mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // first entry of each sequence
    localparam rom_idx_t SINGLE_START    = 4'd1;
    localparam rom_idx_t CHORD_UP_START  = 4'd3;
    localparam rom_idx_t CHORD_DN_START  = 4'd7;

    localparam rom_entry_t TONE_ROM [16] = '{
        '{SEL_END,  8'd0,   8'd0},
        '{SEL_MID,  8'd100, 8'd40},
        '{SEL_END,  8'd0,   8'd0},
        '{SEL_LOW,  8'd20,  8'd30},
        '{SEL_MID,  8'd20,  8'd30},
        '{SEL_HIGH, 8'd220, 8'd40},
        '{SEL_END,  8'd0,   8'd0},
        '{SEL_HIGH, 8'd20,  8'd30},
        '{SEL_MID,  8'd20,  8'd30},
        '{SEL_LOW,  8'd220, 8'd40},
        '{SEL_END,  8'd0,   8'd0},
        '{SEL_END,  8'd0,   8'd0},
        '{SEL_END,  8'd0,   8'd0},
        '{SEL_END,  8'd0,   8'd0},
        '{SEL_END,  8'd0,   8'd0},
        '{SEL_END,  8'd0,   8'd0}
    };

    typedef struct packed {
        logic                  power_on;
        logic                  osc_on;
        logic [OUT_FREQ_W-1:0] freq_code;
        logic                  busy;
    } tone_levels_t;

    tone_levels_t          levels_q[$];

    logic [FREQ_W-1:0]     code_low;
    logic [FREQ_W-1:0]     code_mid;
    logic [FREQ_W-1:0]     code_high;

    phase_t                seq_phase;
    rom_idx_t              cur_entry;
    tick_t                 pwr_left;
    tick_t                 osc_left;
    logic                  pwr_lvl;
    logic                  osc_lvl;
    logic [OUT_FREQ_W-1:0] freq_lvl;

    initial mismatch_count = 0;

    function automatic tone_levels_t advance_sequencer(input logic start, input tone_t tone);
        rom_entry_t   ent;
        tone_levels_t lv;
        if (start)
        begin
            case (tone)
                TONE_POWER_ON:  cur_entry = CHORD_UP_START;
                TONE_POWER_OFF: cur_entry = CHORD_DN_START;
                default:        cur_entry = SINGLE_START;
            endcase
            seq_phase = PH_LOAD;
        end
        else if (seq_phase == PH_LOAD)
        begin
            ent = TONE_ROM[cur_entry];
            pwr_left = ent.pwr;
            osc_left = ent.osc;
            if (ent.sel == SEL_END || ent.pwr == 0)
            begin
                seq_phase = PH_DONE;
            end
            else
            begin
                pwr_left = pwr_left - 1'b1;
                pwr_lvl = 1'b1;
                if (ent.osc == 0)
                begin
                    // no oscillation time: power dropped again, sequence over
                    pwr_lvl = 1'b0;
                    seq_phase = PH_DONE;
                end
                else
                begin
                    osc_left = osc_left - 1'b1;
                    case (ent.sel)
                        SEL_LOW: freq_lvl = OUT_FREQ_W'(code_low);
                        SEL_MID: freq_lvl = OUT_FREQ_W'(code_mid);
                        default: freq_lvl = OUT_FREQ_W'(code_high);
                    endcase
                    osc_lvl = 1'b1;
                    seq_phase = PH_COUNT;
                end
            end
        end
        else if (seq_phase == PH_COUNT)
        begin
            if (pwr_left != 0)
                pwr_left = pwr_left - 1'b1;
            else
                pwr_lvl = 1'b0;
            if (osc_left != 0)
            begin
                osc_left = osc_left - 1'b1;
            end
            else
            begin
                osc_lvl = 1'b0;
                cur_entry = cur_entry + 1'b1;
                seq_phase = PH_LOAD;
            end
        end
        lv.power_on  = pwr_lvl;
        lv.osc_on    = osc_lvl;
        lv.freq_code = freq_lvl;
        lv.busy      = (seq_phase == PH_LOAD) || (seq_phase == PH_COUNT);
        return lv;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tone_levels_t want;
        if (!rst_n)
        begin
            levels_q.delete();
            code_low       = FREQ_W'(CODE_LOW_RESET);
            code_mid       = FREQ_W'(CODE_MID_RESET);
            code_high      = FREQ_W'(CODE_HIGH_RESET);
            seq_phase      = PH_LOAD;
            cur_entry      = '0;
            pwr_left       = '0;
            osc_left       = '0;
            pwr_lvl        = 1'b0;
            osc_lvl        = 1'b0;
            freq_lvl       = '0;
            levels_pending <= 0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                if (levels_q.size() == 0)
                begin
                    $error("result transfer with no expected levels waiting");
                    mismatch_count++;
                end
                else
                begin
                    want = levels_q.pop_front();
                    check_field("power_on", 32'(want.power_on), 32'(m_data[0]));
                    check_field("osc_on", 32'(want.osc_on), 32'(m_data[1]));
                    check_field("freq_code", 32'(want.freq_code), 32'(m_data[17:2]));
                    check_field("busy_res", 32'(want.busy), 32'(m_data[18]));
                    check_field("pad", 32'd0, 32'(m_data[23:19]));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FREQ_LOW:  code_low  = cfg_data;
                    REG_FREQ_MID:  code_mid  = cfg_data;
                    REG_FREQ_HIGH: code_high = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                levels_q.push_back(advance_sequencer(s_user[0], tone_t'(s_data[1:0])));
            levels_pending <= levels_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bts_pkg::*;

    localparam int          FREQ_W      = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          PHASE_ITEMS = 160;

    // tuser values on the input channel
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // register index the block has no register behind
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // receiver hold-off that backs the block up into its input
    localparam int HOLD_AFTER  = 250;
    localparam int HOLD_CYCLES = 200;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              s_axis_tvalid  = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata   = '0;    // [1:0] tone_select, [7:2] zero
    logic [0:0]        s_axis_tuser   = '0;    // [0] mode
    logic              m_axis_tvalid;
    logic              m_axis_tready  = 1'b0;
    logic [23:0]       m_axis_tdata;           // [0] power_on, [1] osc_on,
                                               // [17:2] freq_code, [18] busy_res,
                                               // [23:19] zero
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index      = '0;
    logic [FREQ_W-1:0] cfg_data       = '0;

    int                levels_pending;
    int                mismatch_count;

    // idling knobs, percent per cycle
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;

    int                items_sent     = 0;
    int                results_taken  = 0;
    int                hold_left      = 0;
    logic              hold_done      = 1'b0;
    int unsigned       cycle_count    = 0;

    always #1 clk = ~clk;

    buzzer_tone_sequencer_top #(
        .FREQ_WIDTH(FREQ_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // watches all three channels, predicts each result and compares it
    tone_level_checker #(
        .FREQ_W(FREQ_W)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_valid        (s_axis_tvalid),
        .s_ready        (s_axis_tready),
        .s_data         (s_axis_tdata),
        .s_user         (s_axis_tuser),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_data         (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .levels_pending (levels_pending),
        .mismatch_count (mismatch_count)
    );

    // result side: random stalls, plus one long hold-off once enough transfers went by
    // so the output register fills and the block drops s_axis_tready
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            results_taken <= results_taken + 1;
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!hold_done && results_taken == HOLD_AFTER)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one input transfer; random gaps before it, tvalid stays up between back-to-back items
    task automatic send_item(input logic mode, input tone_t tone);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'b0, tone};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // a start followed by ticks: mostly run to the end and a bit past it,
    // sometimes cut short so the next start lands while busy
    task automatic play_sequence(input tone_t tone);
        int n_ticks;
        n_ticks = ($urandom_range(99) < 30) ? $urandom_range(110, 1) : 110;
        send_item(MODE_START, tone);
        repeat (n_ticks)
            send_item(MODE_TICK, tone_t'($urandom_range(3)));
    endtask

    // stop offering and wait for every predicted result to come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (levels_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_code(input logic [1:0] index, input logic [FREQ_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // none, sender gaps, receiver stalls, both
    task automatic pick_idling(input int kind);
        case (kind)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            1:
            begin
                send_idle_pct = 65;
                recv_stall_pct <= 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 65;
            end
            default:
            begin
                send_idle_pct = 14;
                recv_stall_pct <= 14;
            end
        endcase
    endtask

    initial
    begin
        int phase_goal;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ticks from reset, every selector, restarts while busy
        send_item(MODE_TICK, TONE_SPARE);
        send_item(MODE_TICK, TONE_SINGLE);
        send_item(MODE_START, TONE_SINGLE);
        send_item(MODE_TICK, TONE_POWER_OFF);
        send_item(MODE_TICK, TONE_SINGLE);
        send_item(MODE_START, TONE_POWER_ON);
        send_item(MODE_TICK, TONE_POWER_ON);
        send_item(MODE_TICK, TONE_SPARE);
        send_item(MODE_TICK, TONE_SINGLE);
        send_item(MODE_START, TONE_POWER_OFF);
        send_item(MODE_TICK, TONE_SINGLE);
        send_item(MODE_TICK, TONE_SINGLE);
        send_item(MODE_START, TONE_SPARE);
        send_item(MODE_TICK, TONE_SINGLE);
        send_item(MODE_TICK, TONE_SPARE);
        send_item(MODE_START, TONE_SPARE);
        send_item(MODE_START, TONE_POWER_ON);
        send_item(MODE_TICK, TONE_SINGLE);

        // random phases, each under its own frequency codes and idling
        for (int p = 0; p < 5; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    write_code(REG_FREQ_LOW, '0);
                    write_code(REG_FREQ_MID, '0);
                    write_code(REG_FREQ_HIGH, '0);
                end
                1:
                begin
                    write_code(REG_FREQ_LOW, '1);
                    write_code(REG_FREQ_MID, '1);
                    write_code(REG_FREQ_HIGH, '1);
                end
                2:
                begin
                    write_code(REG_FREQ_HIGH, FREQ_W'($urandom));
                    write_code(REG_FREQ_LOW, FREQ_W'($urandom));
                    write_code(REG_FREQ_MID, FREQ_W'($urandom));
                end
                3:
                begin
                    write_code(REG_FREQ_MID, FREQ_W'($urandom));
                    // no register behind this index, codes must not move
                    write_code(REG_UNUSED, FREQ_W'($urandom));
                    write_code(REG_FREQ_LOW, FREQ_W'($urandom));
                end
                default:
                begin
                    write_code(REG_FREQ_LOW, FREQ_W'(CODE_LOW_RESET));
                    write_code(REG_FREQ_MID, FREQ_W'(CODE_MID_RESET));
                    write_code(REG_FREQ_HIGH, FREQ_W'(CODE_HIGH_RESET));
                end
            endcase
            cfg_valid <= 1'b0;
            pick_idling(p);
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal)
            begin
                // last phase mixes the idling styles sequence by sequence
                if (p == 4)
                    pick_idling($urandom_range(3));
                if ($urandom_range(99) < 15)
                    send_item(1'($urandom_range(1)), tone_t'($urandom_range(3)));
                else
                    play_sequence(tone_t'($urandom_range(3)));
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bts_pkg.sv
hw/rtl/bts_cfg.sv
hw/rtl/bts_core.sv
hw/rtl/buzzer_tone_sequencer_top.sv
tb/sv/tone_level_checker.sv
tb/sv/tb.sv
